FILE: design/cau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and widths for the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 12;
  localparam int PROD_W     = 2 * DATA_WIDTH;       // one signed product
  localparam int DEN_W      = 2 * DATA_WIDTH;       // br^2 + bi^2, unsigned
  localparam int QUO_W      = DEN_W + FRAC_BITS;    // dividend / quotient width

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                          command;
    logic signed [DATA_WIDTH-1:0]  a_real;
    logic signed [DATA_WIDTH-1:0]  a_imag;
    logic signed [DATA_WIDTH-1:0]  b_real;
    logic signed [DATA_WIDTH-1:0]  b_imag;
  } req_word_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]  res_real;
    logic signed [DATA_WIDTH-1:0]  res_imag;
    logic                          overflow;
    logic                          div_zero;
  } rsp_word_t;

  // Word carried through the divider chain: sign of each result part,
  // partial remainders, and dividend bits shifting out as quotient bits shift in.
  typedef struct packed {
    logic              dz;
    logic              neg_r;
    logic              neg_i;
    logic [DEN_W-1:0]  den;
    logic [DEN_W-1:0]  rem_r;
    logic [DEN_W-1:0]  rem_i;
    logic [QUO_W-1:0]  qd_r;
    logic [QUO_W-1:0]  qd_i;
  } div_word_t;

endpackage

FILE: design/cau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Three stages: products, combine, sign/magnitude and divider load.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                req_valid,
  input  cau_pkg::req_word_t  req_data,
  output logic                valid,
  output cau_pkg::div_word_t  word
);

  localparam int W  = cau_pkg::DATA_WIDTH;
  localparam int PW = cau_pkg::PROD_W;
  localparam int DW = cau_pkg::DEN_W;
  localparam int QW = cau_pkg::QUO_W;
  localparam int F  = cau_pkg::FRAC_BITS;

  // stage 1
  logic                 v1;
  cau_pkg::cmd_t        cmd1;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, sq_r, sq_i;
  logic signed [W:0]    s_r, s_i;
  // stage 2
  logic                 v2;
  cau_pkg::cmd_t        cmd2;
  logic signed [PW:0]   x_r, x_i;
  logic [DW-1:0]        den2;

  logic signed [W:0]    ar_x, ai_x, br_x, bi_x;
  logic signed [PW:0]   rr_x, ii_x, ri_x, ir_x;
  logic signed [PW:0]   x_r_next, x_i_next;
  logic [PW-1:0]        mag_r, mag_i;
  cau_pkg::div_word_t   word_next;

  assign ar_x = {req_data.a_real[W-1], req_data.a_real};
  assign ai_x = {req_data.a_imag[W-1], req_data.a_imag};
  assign br_x = {req_data.b_real[W-1], req_data.b_real};
  assign bi_x = {req_data.b_imag[W-1], req_data.b_imag};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= req_valid;
    end
    if (en) begin
      cmd1 <= req_data.command;
      p_rr <= req_data.a_real * req_data.b_real;
      p_ii <= req_data.a_imag * req_data.b_imag;
      p_ri <= req_data.a_real * req_data.b_imag;
      p_ir <= req_data.a_imag * req_data.b_real;
      sq_r <= req_data.b_real * req_data.b_real;
      sq_i <= req_data.b_imag * req_data.b_imag;
      s_r  <= (req_data.command == cau_pkg::CMD_SUB) ? ar_x - br_x : ar_x + br_x;
      s_i  <= (req_data.command == cau_pkg::CMD_SUB) ? ai_x - bi_x : ai_x + bi_x;
    end
  end

  assign rr_x = {p_rr[PW-1], p_rr};
  assign ii_x = {p_ii[PW-1], p_ii};
  assign ri_x = {p_ri[PW-1], p_ri};
  assign ir_x = {p_ir[PW-1], p_ir};

  always_comb begin
    unique case (cmd1)
      cau_pkg::CMD_MUL: begin
        x_r_next = rr_x - ii_x;
        x_i_next = ri_x + ir_x;
      end
      cau_pkg::CMD_DIV: begin
        x_r_next = rr_x + ii_x;
        x_i_next = ir_x - ri_x;
      end
      default: begin
        x_r_next = {{(PW-W){s_r[W]}}, s_r};
        x_i_next = {{(PW-W){s_i[W]}}, s_i};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      cmd2 <= cmd1;
      x_r  <= x_r_next;
      x_i  <= x_i_next;
      den2 <= DW'($unsigned(sq_r) + $unsigned(sq_i));
    end
  end

  // magnitudes never exceed 2^(PW-1), so PW bits hold them
  assign mag_r = x_r[PW] ? PW'(-x_r) : x_r[PW-1:0];
  assign mag_i = x_i[PW] ? PW'(-x_i) : x_i[PW-1:0];

  // non-divide results pass the chain as a quotient over one
  always_comb begin
    word_next       = '0;
    word_next.neg_r = x_r[PW];
    word_next.neg_i = x_i[PW];
    word_next.den   = DW'(1);
    unique case (cmd2)
      cau_pkg::CMD_MUL: begin
        word_next.qd_r = QW'(mag_r >> F);
        word_next.qd_i = QW'(mag_i >> F);
      end
      cau_pkg::CMD_DIV: begin
        if (den2 == '0) begin
          word_next.dz    = 1'b1;
          word_next.neg_r = 1'b0;
          word_next.neg_i = 1'b0;
        end else begin
          word_next.den  = den2;
          word_next.qd_r = QW'(mag_r) << F;
          word_next.qd_i = QW'(mag_i) << F;
        end
      end
      default: begin
        word_next.qd_r = QW'(mag_r);
        word_next.qd_i = QW'(mag_i);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= v2;
    end
    if (en) begin
      word <= word_next;
    end
  end

endmodule

FILE: design/cau_div_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_div_step
// One registered restoring-division step for both result parts.
// ----------------------------------------------------------------------------
module cau_div_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  cau_pkg::div_word_t  in_word,
  output logic                valid,
  output cau_pkg::div_word_t  word
);

  localparam int DW = cau_pkg::DEN_W;
  localparam int QW = cau_pkg::QUO_W;

  logic [DW:0]        trial_r, trial_i, diff_r, diff_i;
  logic               ge_r, ge_i;
  cau_pkg::div_word_t word_next;

  assign trial_r = {in_word.rem_r, in_word.qd_r[QW-1]};
  assign trial_i = {in_word.rem_i, in_word.qd_i[QW-1]};
  assign ge_r    = trial_r >= {1'b0, in_word.den};
  assign ge_i    = trial_i >= {1'b0, in_word.den};
  assign diff_r  = trial_r - {1'b0, in_word.den};
  assign diff_i  = trial_i - {1'b0, in_word.den};

  always_comb begin
    word_next       = in_word;
    word_next.rem_r = ge_r ? diff_r[DW-1:0] : trial_r[DW-1:0];
    word_next.rem_i = ge_i ? diff_i[DW-1:0] : trial_i[DW-1:0];
    word_next.qd_r  = {in_word.qd_r[QW-2:0], ge_r};
    word_next.qd_i  = {in_word.qd_i[QW-2:0], ge_i};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
    if (en) begin
      word <= word_next;
    end
  end

endmodule

FILE: design/cau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_back
// Saturation, output register and skid word; drives the pipeline enable.
// ----------------------------------------------------------------------------
module cau_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  cau_pkg::div_word_t  in_word,
  output logic                en,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output cau_pkg::rsp_word_t  rsp_data
);

  localparam int W  = cau_pkg::DATA_WIDTH;
  localparam int QW = cau_pkg::QUO_W;
  localparam logic [QW-1:0] LIM_POS = QW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [QW-1:0] LIM_NEG = QW'(64'd1 << (W - 1));

  logic               skid_valid;
  cau_pkg::rsp_word_t skid_data, res;
  logic [W-1:0]       val_r, val_i;
  logic               ovf_r, ovf_i;

  function automatic logic [W:0] sat(input logic neg, input logic [QW-1:0] q);
    logic [W:0] r;
    if (!neg) begin
      if (q > LIM_POS) r = {1'b1, 1'b0, {(W-1){1'b1}}};
      else             r = {1'b0, q[W-1:0]};
    end else begin
      if (q > LIM_NEG) r = {1'b1, 1'b1, {(W-1){1'b0}}};
      else             r = {1'b0, W'(-q[W-1:0])};
    end
    return r;
  endfunction

  assign {ovf_r, val_r} = sat(in_word.neg_r, in_word.qd_r);
  assign {ovf_i, val_i} = sat(in_word.neg_i, in_word.qd_i);

  always_comb begin
    res.res_real = val_r;
    res.res_imag = val_i;
    res.overflow = ovf_r | ovf_i;
    res.div_zero = in_word.dz;
  end

  assign en = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (rsp_valid && !rsp_ready) begin
      if (en && in_valid) begin
        skid_valid <= 1'b1;
        skid_data  <= res;
      end
    end else if (skid_valid) begin
      rsp_valid  <= 1'b1;
      rsp_data   <= skid_data;
      skid_valid <= 1'b0;
    end else begin
      rsp_valid <= in_valid;
      rsp_data  <= res;
    end
  end

endmodule

FILE: design/complex_arith_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arith_unit
// Pipelined complex add, subtract, multiply and divide on Q3.12 operands.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | word
//  --------+------------------------+--------------------------------------
//  request | req_valid / req_ready  | req_data: command, a and b parts
//  result  | rsp_valid / rsp_ready  | rsp_data: result parts, overflow, div_zero
//
// One word enters per cycle unless a result-side stall holds the pipeline; the
// divider chain makes one quotient bit per stage, QUO_W = 2*W + F.
// Every command takes the full chain, so results leave in request order.
// Reset (rst, synchronous) empties all stages, the output and the skid word.
// A stall on the result side parks one word in the skid register; the whole
// pipeline then holds until it drains, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module complex_arith_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  cau_pkg::req_word_t  req_data,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output cau_pkg::rsp_word_t  rsp_data
);

  localparam int QW = cau_pkg::QUO_W;

  logic               en;
  logic               stg_valid [0:QW];
  cau_pkg::div_word_t stg_word  [0:QW];

  // ready depends only on the registered skid state
  assign req_ready = en;

  // products, combine, sign/magnitude
  cau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .req_valid (req_valid),
    .req_data  (req_data),
    .valid     (stg_valid[0]),
    .word      (stg_word[0])
  );

  // restoring divider, one quotient bit per stage; other commands divide by one
  for (genvar k = 0; k < QW; k++) begin : g_div
    cau_div_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (stg_valid[k]),
      .in_word  (stg_word[k]),
      .valid    (stg_valid[k+1]),
      .word     (stg_word[k+1])
    );
  end

  // saturate and present
  cau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stg_valid[QW]),
    .in_word   (stg_word[QW]),
    .en        (en),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
  );

endmodule

FILE: dv/tb_complex_arith_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_arith_unit
// Self-checking bench for the complex arithmetic unit: directed corner words
// then random traffic, each result checked against a behavioural predictor.
// ----------------------------------------------------------------------------
module tb_complex_arith_unit;

  localparam int  DATA_WIDTH      = cau_pkg::DATA_WIDTH;
  localparam int  FRAC_BITS       = cau_pkg::FRAC_BITS;
  localparam int  WATCHDOG_CYCLES = 20000;
  localparam int  LATENCY         = 3 + cau_pkg::QUO_W + 1;
  localparam logic signed [DATA_WIDTH-1:0] SMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] SMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  cau_pkg::req_word_t req_data = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  cau_pkg::rsp_word_t rsp_data;

  cau_pkg::rsp_word_t expected_results[$];
  int        mismatches = 0;
  bit        stray_seen = 1'b0;
  int        idle_cycles = 0;

  complex_arith_unit DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Saturate a wide signed value to the result range; flag on clip.
  function automatic logic [DATA_WIDTH-1:0] clip(input logic signed [127:0] v,
                                                 inout logic ovf);
    if (v > SMAX) begin
      ovf = 1'b1;
      return SMAX;
    end
    if (v < SMIN) begin
      ovf = 1'b1;
      return SMIN;
    end
    return v[DATA_WIDTH-1:0];
  endfunction

  // Drop fraction bits, truncating toward zero.
  function automatic logic signed [127:0] trunc_frac(input logic signed [127:0] v);
    logic signed [127:0] m;
    m = (v < 0) ? -v : v;
    m = m >>> FRAC_BITS;
    return (v < 0) ? -m : m;
  endfunction

  // num * 2^F / den, truncated toward zero; den is positive.
  function automatic logic signed [127:0] quot_trunc(input logic signed [127:0] num,
                                                     input logic signed [127:0] den);
    logic signed [127:0] m;
    m = (num < 0) ? -num : num;
    m = (m <<< FRAC_BITS) / den;
    return (num < 0) ? -m : m;
  endfunction

  function automatic cau_pkg::rsp_word_t complex_result(input cau_pkg::req_word_t w);
    cau_pkg::rsp_word_t r;
    logic signed [127:0] ar, ai, br, bi, den;
    logic ovf;
    ar = w.a_real; ai = w.a_imag; br = w.b_real; bi = w.b_imag;
    ovf = 1'b0;
    r = '0;
    case (w.command)
      cau_pkg::CMD_ADD: begin
        r.res_real = clip(ar + br, ovf);
        r.res_imag = clip(ai + bi, ovf);
      end
      cau_pkg::CMD_SUB: begin
        r.res_real = clip(ar - br, ovf);
        r.res_imag = clip(ai - bi, ovf);
      end
      cau_pkg::CMD_MUL: begin
        r.res_real = clip(trunc_frac(ar * br - ai * bi), ovf);
        r.res_imag = clip(trunc_frac(ar * bi + ai * br), ovf);
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.div_zero = 1'b1;
        end else begin
          r.res_real = clip(quot_trunc(ar * br + ai * bi, den), ovf);
          r.res_imag = clip(quot_trunc(ai * br - ar * bi, den), ovf);
        end
      end
    endcase
    r.overflow = ovf;
    return r;
  endfunction

  // Random gap: mostly none or short, now and then long.
  function automatic int random_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  bit quiet_sink = 1'b0;  // no stalls on the result side while set

  // Result side: random stalls, every accepted word checked in order.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_results.size() == 0) begin
          if (!stray_seen) $display("ERROR: result word with none expected");
          stray_seen = 1'b1;
          mismatches++;
        end else begin
          cau_pkg::rsp_word_t e;
          e = expected_results.pop_front();
          if (rsp_data !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: got re=%0d im=%0d ov=%b dz=%b, exp re=%0d im=%0d ov=%b dz=%b",
                       rsp_data.res_real, rsp_data.res_imag, rsp_data.overflow,
                       rsp_data.div_zero, e.res_real, e.res_imag, e.overflow,
                       e.div_zero);
          end
        end
      end
      rsp_ready <= quiet_sink ? 1'b1 : (random_gap() == 0);
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Present one word, hold until taken, log its prediction.
  task automatic send_word(input cau_pkg::req_word_t w);
    req_valid <= 1'b1;
    req_data  <= w;
    do @(posedge clk); while (!req_ready);
    expected_results.push_back(complex_result(w));
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [DATA_WIDTH-1:0] random_part();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return SMAX;
    if (p == 1) return SMIN;
    if (p == 2) return '0;
    if (p < 5) return DATA_WIDTH'($urandom_range(0, 2 ** (FRAC_BITS + 1)) - 2 ** FRAC_BITS);
    return DATA_WIDTH'($urandom);
  endfunction

  function automatic cau_pkg::req_word_t make_word(input cau_pkg::cmd_t c,
                                                   input logic [DATA_WIDTH-1:0] ar,
                                                   input logic [DATA_WIDTH-1:0] ai,
                                                   input logic [DATA_WIDTH-1:0] br,
                                                   input logic [DATA_WIDTH-1:0] bi);
    cau_pkg::req_word_t w;
    w.command = c; w.a_real = ar; w.a_imag = ai; w.b_real = br; w.b_imag = bi;
    return w;
  endfunction

  function automatic cau_pkg::cmd_t random_cmd();
    return cau_pkg::cmd_t'(2'($urandom_range(0, 3)));
  endfunction

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Extremes per command, divide by zero, saturation both ways.
  task automatic test_directed();
    cau_pkg::cmd_t c;
    c = c.first();
    do begin
      send_word(make_word(c, SMAX, SMAX, SMAX, SMAX));
      send_word(make_word(c, SMIN, SMIN, SMIN, SMIN));
      send_word(make_word(c, SMAX, SMIN, SMIN, SMAX));
      send_word(make_word(c, 16'h1000, 16'hF000, 16'h0800, 16'h1000));
      send_word(make_word(c, '0, '0, 16'h0001, '0));
      c = c.next();
    end while (c != c.first());
    send_word(make_word(cau_pkg::CMD_DIV, 16'h1234, SMIN, '0, '0));  // divide by zero
    send_word(make_word(cau_pkg::CMD_DIV, SMAX, SMAX, 16'h0001, 16'h0001));  // huge quotient
    send_word(make_word(cau_pkg::CMD_DIV, SMIN, '0, 16'hFFFF, '0));
  endtask

  task automatic test_random(input int n);
    repeat (n) begin
      send_word(make_word(random_cmd(), random_part(), random_part(),
                          random_part(), random_part()));
      idle_for(random_gap());
    end
  endtask

  // Back-to-back stream with the sink always ready.
  task automatic test_full_rate(input int n);
    quiet_sink = 1'b1;
    repeat (n)
      send_word(make_word(random_cmd(), DATA_WIDTH'($urandom), DATA_WIDTH'($urandom),
                          DATA_WIDTH'($urandom), DATA_WIDTH'($urandom)));
    quiet_sink = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(800);
    wait_drained();  // sender holds off until all results are in
    test_full_rate(200);
    test_random(630);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
